// ----- src/suis_pkg.sv -----
// ----------------------------------------------------------------------------
// suis_pkg: shared types and codes for the sorted unique key sets
// Word formats of the request and result ports, status and command codes,
// and the control group that the top level sends down the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package suis_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int ECNT_W   = 6;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             command;
        logic             list_select;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ECNT_W-1:0]   entry_count;
    } t_out_word;

    // control group broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the request key
        logic ins_en;   // apply the ordered insert (shift up / store key)
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- src/suis_cell.sv -----
// ----------------------------------------------------------------------------
// suis_cell: one slot position of the sorted sets
// Holds the key at this position for every set, compares it with the request
// key and, on insert, takes either the new key or its left neighbor's key.
// ----------------------------------------------------------------------------
`default_nettype none

module suis_cell #(
    parameter int CELL_INDEX = 0,
    parameter int NUM_LISTS  = 2,
    parameter int LS_W       = 1,
    parameter int CNT_W      = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire suis_pkg::t_cell_ctl        i_ctl,
    input  wire logic [LS_W-1:0]            i_lst,
    input  wire logic [CNT_W-1:0]           i_count,
    input  wire logic [suis_pkg::KEY_W-1:0] i_key,
    input  wire logic [suis_pkg::KEY_W-1:0] i_left_key,
    input  wire logic                       i_left_lt,
    output logic      [suis_pkg::KEY_W-1:0] o_key,
    output logic                            o_lt,
    output logic                            o_eq
);

    logic [suis_pkg::KEY_W-1:0] r_key [NUM_LISTS];
    logic                       r_lt;
    logic                       r_eq;
    logic                       w_valid;
    logic                       w_in_span;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_INDEX);

    assign o_key     = r_key[i_lst];
    assign w_valid   = MY_IDX < i_count;
    // slot may receive the neighbor's key when the neighbor held an entry
    assign w_in_span = (CELL_INDEX > 0) && (MY_IDX <= i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_lt <= w_valid && (o_key < i_key);
            r_eq <= w_valid && (o_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (i_left_lt && !r_lt) begin
                r_key[i_lst] <= i_key;
            end else if (!i_left_lt && w_in_span) begin
                r_key[i_lst] <= i_left_key;
            end
        end
    end

    assign o_lt = r_lt;
    assign o_eq = r_eq;

endmodule

`default_nettype wire

// ----- src/sorted_unique_set_insert_lookup_top.sv -----
// ----------------------------------------------------------------------------
// sorted_unique_set_insert_lookup_top: sorted unique 32-bit key sets
// Sequence: an accepted request is registered, its compare flags are latched in
//   S_CMP, and its result word and o_valid are registered at the end of S_EXEC.
// A new request is taken only back in S_IDLE; busy covers the compare and the
//   update cycle, independent of set size (all cells compare in parallel).
// Reset (synchronous, active low) empties every set; key slots are not
//   cleared, entries above a set's count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_insert_lookup_top #(
    parameter int LIST_CAPACITY = 32,
    parameter int NUM_LISTS     = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire suis_pkg::t_in_word   i_word,
    output logic                      busy,
    output logic                      o_valid,
    output suis_pkg::t_out_word       o_word
);

    // count needs to hold LIST_CAPACITY itself
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int LS_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LIST_CAPACITY);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]              r_state, n_state;
    suis_pkg::t_in_word      r_req;
    logic [CNT_W-1:0]        r_len [NUM_LISTS];
    logic                    r_valid, n_valid;
    suis_pkg::t_out_word     r_out, n_out;

    logic                    w_accept;
    logic                    w_sel_ok;
    logic [LS_W-1:0]         w_lst;
    logic [CNT_W-1:0]        w_count;
    logic                    w_hit;
    logic                    w_do_ins;
    suis_pkg::t_cell_ctl     w_ctl;

    // per-cell taps along the chain
    logic [suis_pkg::KEY_W-1:0] w_cell_key [LIST_CAPACITY];
    logic [LIST_CAPACITY-1:0]   w_lt;
    logic [LIST_CAPACITY-1:0]   w_eq;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // a select beyond the configured sets is refused without touching state
    assign w_sel_ok = {31'b0, r_req.list_select} < 32'(NUM_LISTS);
    assign w_lst    = LS_W'(r_req.list_select) & {LS_W{w_sel_ok}};
    assign w_count  = w_sel_ok ? r_len[w_lst] : '0;

    assign w_hit    = |w_eq;
    assign w_do_ins = w_sel_ok && (r_req.command == suis_pkg::CMD_INSERT)
                   && !w_hit && (w_count < CAP);

    assign w_ctl.cmp_en = (r_state == S_CMP);
    assign w_ctl.ins_en = (r_state == S_EXEC) && w_do_ins;

    // row of cells: each sees its left neighbor's key and less-than flag
    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        logic [suis_pkg::KEY_W-1:0] w_left_key;
        logic                       w_left_lt;

        if (g == 0) begin : g_head
            assign w_left_key = r_req.key;
            assign w_left_lt  = 1'b1;
        end else begin : g_body
            assign w_left_key = w_cell_key[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        suis_cell #(
            .CELL_INDEX (g),
            .NUM_LISTS  (NUM_LISTS),
            .LS_W       (LS_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_lst      (w_lst),
            .i_count    (w_count),
            .i_key      (r_req.key),
            .i_left_key (w_left_key),
            .i_left_lt  (w_left_lt),
            .o_key      (w_cell_key[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    // next state and result word
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_out   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                n_out.entry_count = suis_pkg::ECNT_W'(w_count);
                priority if (!w_sel_ok) begin
                    n_out.status = (r_req.command == suis_pkg::CMD_LOOKUP)
                                 ? suis_pkg::ST_NOT_FOUND : suis_pkg::ST_FULL;
                end else if (r_req.command == suis_pkg::CMD_LOOKUP) begin
                    n_out.status = w_hit ? suis_pkg::ST_FOUND
                                         : suis_pkg::ST_NOT_FOUND;
                end else if (w_hit) begin
                    n_out.status = suis_pkg::ST_PRESENT;
                end else if (!w_do_ins) begin
                    n_out.status = suis_pkg::ST_FULL;
                end else begin
                    n_out.status      = suis_pkg::ST_INSERTED;
                    n_out.entry_count = suis_pkg::ECNT_W'(w_count + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (w_ctl.ins_en) begin
                r_len[w_lst] <= w_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_req <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a result word only follows the update cycle
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result word without update cycle");

    // an accepted request always enters the compare cycle
    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_CMP))
        else $error("accepted request did not start compare");

    // set 0 never grows past its capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[0] <= CAP)
        else $error("set length above capacity");

    // an inserted result never reports an entry count of zero, unless the capacity reaches 64 and the count can wrap
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.status == suis_pkg::ST_INSERTED)
            |-> (o_word.entry_count != 6'd0 || LIST_CAPACITY >= 64))
        else $error("insert reported empty set");

endmodule

`default_nettype wire
